### sv/kruskal_tree_completion_core_defines.svh
// Assertion macros used by the checker file of the tree completion core.
`ifndef KRUSKAL_TREE_COMPLETION_CORE_DEFINES_SVH
`define KRUSKAL_TREE_COMPLETION_CORE_DEFINES_SVH

// same-cycle implication
`define KTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ktc_props: property violated");

// next-cycle implication
`define KTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ktc_props: property violated");

`endif

### sv/ktc_pkg.sv
// Shared types and constants of the tree completion core.
package ktc_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VTX_W        = 6;
   localparam int CNT_W        = 7;
   localparam int PROD_W       = 2 * CNT_W;
   localparam int CAND_W       = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
   localparam int STEP_W       = $clog2(MAX_VERTICES);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0] VC_RESET = CNT_W'(64);

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_FORCED = 2'd1;
   localparam logic [1:0] KIND_CAND   = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_FORCED,
      OP_CAND,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND_A,
      ST_FIND_B,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic [VTX_W-1:0] slot;
      logic [VTX_W-1:0] out_a;
      logic [VTX_W-1:0] out_b;
      logic             tree_complete;
      logic             overrun;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic              ends_ok;
      logic [VTX_W-1:0]  a;
      logic [VTX_W-1:0]  b;
      logic [CNT_W-1:0]  need;
      logic [CAND_W-1:0] limit;
   } cmd_type;

endpackage

### sv/ktc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ktc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ktc_front.sv
// Front end: vertex count register, request decode and edge pre-checks.
module ktc_front
   import ktc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   input  logic             queue_full,
   output logic             push,
   output cmd_type          push_cmd
);

   logic [CNT_W-1:0]  vc_ff;
   logic [CNT_W-1:0]  vc_in;
   logic [CNT_W-1:0]  n_used;
   logic [PROD_W-1:0] prod;

   always_comb begin
      vc_in = csr_we ? csr_wdata : vc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
      end else begin
         vc_ff <= vc_in;
      end
   end

   always_comb begin
      if (vc_ff < CNT_W'(2)) begin
         n_used = CNT_W'(2);
      end else if (vc_ff > CNT_W'(MAX_VERTICES)) begin
         n_used = CNT_W'(MAX_VERTICES);
      end else begin
         n_used = vc_ff;
      end
      prod = PROD_W'(n_used) * PROD_W'(n_used - CNT_W'(1));
   end

   always_comb begin
      push_cmd.a       = req_data.vertex_a;
      push_cmd.b       = req_data.vertex_b;
      push_cmd.need    = n_used - CNT_W'(1);
      push_cmd.limit   = CAND_W'(prod >> 1);
      push_cmd.ends_ok = (CNT_W'(req_data.vertex_a) < n_used) &&
                         (CNT_W'(req_data.vertex_b) < n_used);
      case (req_data.kind)
         KIND_CLEAR: begin
            push_cmd.op = OP_CLEAR;
         end
         KIND_FORCED: begin
            push_cmd.op = OP_FORCED;
         end
         KIND_CAND: begin
            push_cmd.op = OP_CAND;
         end
         default: begin
            push_cmd.op = OP_NONE;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

### sv/ktc_queue.sv
// Short command queue between the front end and the union-find engine.
module ktc_queue
   import ktc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/ktc_back.sv
// Union-find engine: parent store, root walks, merges, counters and result register.
module ktc_back
   import ktc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type               state_ff;
   state_type               state_in;
   cmd_type                 cmd_ff;
   cmd_type                 cmd_in;
   logic [CNT_W-1:0]        edge_ff;
   logic [CNT_W-1:0]        edge_in;
   logic [CAND_W-1:0]       cand_ff;
   logic [CAND_W-1:0]       cand_in;
   logic                    over_ff;
   logic                    over_in;
   logic [MAX_VERTICES-1:0] valid_ff;
   logic [MAX_VERTICES-1:0] valid_in;
   logic [VTX_W-1:0]        cur_ff;
   logic [VTX_W-1:0]        cur_in;
   logic [STEP_W-1:0]       step_ff;
   logic [STEP_W-1:0]       step_in;
   logic [VTX_W-1:0]        root_a_ff;
   logic [VTX_W-1:0]        root_a_in;
   logic                    vld_q_ff;
   rsp_type                 pend_ff;
   rsp_type                 pend_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   logic                    ram_we;
   logic [VTX_W-1:0]        ram_wr_addr;
   logic [VTX_W-1:0]        ram_wr_data;
   logic [VTX_W-1:0]        ram_rd_addr;
   logic [VTX_W-1:0]        ram_rd_data;

   logic [VTX_W-1:0]        parent;
   logic                    at_root;
   logic                    walk_done;
   logic [VTX_W-1:0]        root;
   logic                    out_free;
   logic                    room;
   logic                    start_find;

   ktc_ram #(
      .WIDTH (VTX_W),
      .DEPTH (MAX_VERTICES)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // an entry never written since clear is its own parent
   always_comb begin
      parent    = vld_q_ff ? ram_rd_data : cur_ff;
      at_root   = parent == cur_ff;
      walk_done = at_root || (step_ff == STEP_W'(MAX_VERTICES - 1));
      root      = at_root ? cur_ff : parent;
      out_free  = !rsp_valid_ff || rsp_ready;
      room      = edge_ff < cmd.need;
      case (cmd.op)
         OP_FORCED: begin
            start_find = cmd.ends_ok && room;
         end
         OP_CAND: begin
            start_find = cmd.ends_ok && room && (cand_ff < cmd.limit);
         end
         default: begin
            start_find = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = start_find ? ST_FIND_A : ST_EMIT;
            end
         end
         ST_FIND_A: begin
            if (walk_done) begin
               state_in = ST_FIND_B;
            end
         end
         ST_FIND_B: begin
            if (walk_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop      = 1'b0;
      cmd_in       = cmd_ff;
      edge_in      = edge_ff;
      cand_in      = cand_ff;
      over_in      = over_ff;
      valid_in     = valid_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      root_a_in    = root_a_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_wr_addr  = root_a_ff;
      ram_wr_data  = root;
      ram_rd_addr  = parent;
      case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = cmd.a;
            if (cmd_valid) begin
               cmd_pop               = 1'b1;
               cmd_in                = cmd;
               cur_in                = cmd.a;
               step_in               = '0;
               pend_in               = '0;
               pend_in.out_a         = cmd.a;
               pend_in.out_b         = cmd.b;
               case (cmd.op)
                  OP_CLEAR: begin
                     valid_in      = '0;
                     edge_in       = '0;
                     cand_in       = '0;
                     over_in       = 1'b0;
                     pend_in.out_a = '0;
                     pend_in.out_b = '0;
                  end
                  OP_CAND: begin
                     if (room) begin
                        if (cand_ff >= cmd.limit) begin
                           over_in = 1'b1;
                        end else begin
                           cand_in = cand_ff + CAND_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIND_A: begin
            if (walk_done) begin
               root_a_in   = root;
               cur_in      = cmd_ff.b;
               step_in     = '0;
               ram_rd_addr = cmd_ff.b;
            end else begin
               cur_in  = parent;
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FIND_B: begin
            if (walk_done) begin
               if ((cmd_ff.op == OP_FORCED) || (root_a_ff != root)) begin
                  pend_in.accepted = 1'b1;
                  pend_in.slot     = edge_ff[VTX_W-1:0];
                  edge_in          = edge_ff + CNT_W'(1);
                  if (root_a_ff != root) begin
                     ram_we              = 1'b1;
                     valid_in[root_a_ff] = 1'b1;
                  end
               end
            end else begin
               cur_in  = parent;
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = pend_ff;
               rsp_in.tree_complete = edge_ff >= cmd_ff.need;
               rsp_in.overrun       = over_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edge_ff      <= '0;
         cand_ff      <= '0;
         over_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_ff      <= edge_in;
         cand_ff      <= cand_in;
         over_ff      <= over_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      cur_ff    <= cur_in;
      step_ff   <= step_in;
      root_a_ff <= root_a_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
      vld_q_ff  <= valid_ff[ram_rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/kruskal_tree_completion_core.sv
// Clear, ignored and rejected transactions pass from the idle state straight to the emit state;
// an edge that is walked goes through FIND_A and FIND_B, which follow the parent chains
// of its endpoints (one parent RAM read per cycle through a single read port).
// The engine handles one transaction at a time; the command queue holds up to two more.
// Synchronous active-high reset: every vertex its own class, counters cleared,
// vertex count 64; the parent store needs no clearing pass and is ready at once.
module kruskal_tree_completion_core
   import ktc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   ktc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ktc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ktc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/ktc_checker.sv
// Port-level assertions for the tree completion core and their bind.
`include "kruskal_tree_completion_core_defines.svh"

module ktc_props
   import ktc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `KTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))
   `KTC_ASSERT_NOW(a_reject_slot, clock, reset, rsp_valid && !rsp_data.accepted,
      rsp_data.slot == '0)
   `KTC_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)
   `KTC_ASSERT_NOW(a_accept_not_full, clock, reset, rsp_valid && rsp_data.accepted,
      rsp_data.slot != '1 || rsp_data.tree_complete)

endmodule

bind kruskal_tree_completion_core ktc_props u_ktc_props (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/ktc_checker.sv
// Checker for the tree completion core: predicts each result and compares it.
module ktc_checker
   import ktc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   output int               mismatches,
   output int               outstanding
);

   logic [VTX_W-1:0] parent [MAX_VERTICES];
   logic [CNT_W-1:0] edge_count;
   int               cand_count;
   logic             overrun_seen;
   logic [CNT_W-1:0] vcount_reg;
   rsp_type          pending_results[$];
   int               fail_count = 0;

   function automatic int vertices_in_use();
      if (vcount_reg < 2) return 2;
      if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
      return int'(vcount_reg);
   endfunction

   function automatic logic [VTX_W-1:0] class_root(logic [VTX_W-1:0] v);
      for (int s = 0; s < MAX_VERTICES; s++) begin
         if (parent[v] == v) break;
         v = parent[v];
      end
      return v;
   endfunction

   function automatic void clear_forest();
      for (int i = 0; i < MAX_VERTICES; i++) parent[i] = VTX_W'(i);
      edge_count   = '0;
      cand_count   = 0;
      overrun_seen = 1'b0;
   endfunction

   function automatic void join_classes(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
      logic [VTX_W-1:0] ra;
      logic [VTX_W-1:0] rb;
      ra = class_root(a);
      rb = class_root(b);
      if (ra != rb) parent[ra] = rb;
   endfunction

   function automatic void take_edge(ref rsp_type o, input req_type r);
      o.accepted = 1'b1;
      o.slot     = edge_count[VTX_W-1:0];
      join_classes(r.vertex_a, r.vertex_b);
      edge_count = edge_count + 1'b1;
   endfunction

   function automatic rsp_type place_edge(req_type r);
      int      n;
      int      need;
      int      cand_limit;
      logic    ends_ok;
      rsp_type o;
      n          = vertices_in_use();
      need       = n - 1;
      cand_limit = n * (n - 1) / 2;
      ends_ok    = (int'(r.vertex_a) < n) && (int'(r.vertex_b) < n);
      o          = '0;
      o.out_a    = r.vertex_a;
      o.out_b    = r.vertex_b;
      case (r.kind)
         KIND_CLEAR: begin
            clear_forest();
            o.out_a = '0;
            o.out_b = '0;
         end
         KIND_FORCED: begin
            if (ends_ok && int'(edge_count) < need) take_edge(o, r);
         end
         KIND_CAND: begin
            if (int'(edge_count) < need) begin
               if (cand_count >= cand_limit) begin
                  overrun_seen = 1'b1;
               end else begin
                  cand_count++;
                  if (ends_ok && class_root(r.vertex_a) != class_root(r.vertex_b))
                     take_edge(o, r);
               end
            end
         end
         default: begin
         end
      endcase
      o.tree_complete = (int'(edge_count) >= need);
      o.overrun       = overrun_seen;
      return o;
   endfunction

   task automatic check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_forest();
         vcount_reg = VC_RESET;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with no expectation pending");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("accepted", int'(want.accepted), int'(rsp_data.accepted));
               check_field("slot", int'(want.slot), int'(rsp_data.slot));
               check_field("out_a", int'(want.out_a), int'(rsp_data.out_a));
               check_field("out_b", int'(want.out_b), int'(rsp_data.out_b));
               check_field("tree_complete", int'(want.tree_complete),
                           int'(rsp_data.tree_complete));
               check_field("overrun", int'(want.overrun), int'(rsp_data.overrun));
            end
         end
         if (csr_we) vcount_reg = csr_wdata;
         if (req_valid && req_ready) pending_results.push_back(place_edge(req_data));
      end
      outstanding <= pending_results.size();
      mismatches  <= fail_count;
   end

endmodule

### tb/sv/testbench.sv
// Top of the tree completion core testbench: stimulus, flow control and verdict.
module testbench;
   import ktc_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 1500000;
   localparam int         PHASE_ITEMS = 65;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;
   int               mismatches;
   int               outstanding;

   bit no_idle = 1'b0;
   int cur_n = MAX_VERTICES;
   int items_sent = 0;
   int stall_left = 0;
   int cycles = 0;

   kruskal_tree_completion_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ktc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[kruskal_tree_completion_core] ERROR");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(3) == 0) stall_left <= idle_gap();
      end
   end

   function automatic int any_vertex();
      if ($urandom_range(9) == 0) return $urandom_range(63);
      return $urandom_range(cur_n - 1);
   endfunction

   task automatic send(logic [1:0] kind, int a, int b);
      int      g;
      req_type r;
      g          = idle_gap();
      r.kind     = kind;
      r.vertex_a = a[VTX_W-1:0];
      r.vertex_b = b[VTX_W-1:0];
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_noise();
      send(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
   endtask

   // register writes only once every result is back and the core has settled
   task automatic set_vertices(int v);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CNT_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_n = (v < 2) ? 2 : (v > MAX_VERTICES) ? MAX_VERTICES : v;
   endtask

   task automatic run_phase(int budget);
      int start;
      int cand_limit;
      int hi;
      int cnum;
      int k;
      bit stuck;
      start      = items_sent;
      cand_limit = cur_n * (cur_n - 1) / 2;
      while (items_sent - start < budget) begin
         if ($urandom_range(99) < 85) begin
            send(KIND_CLEAR, $urandom_range(63), $urandom_range(63));
            repeat ($urandom_range(cur_n / 4)) send(KIND_FORCED, any_vertex(), any_vertex());
            // stuck trees revisit only vertices 0 and 1, apart from noise, driving toward overrun
            stuck = ($urandom_range(4) == 0);
            hi    = (cand_limit + 3 > 120) ? 120 : cand_limit + 3;
            cnum  = stuck ? hi : $urandom_range(hi, cur_n - 1);
            k     = 0;
            repeat (cnum) begin
               if ($urandom_range(19) == 0) begin
                  send_noise();
               end else if (stuck) begin
                  send(KIND_CAND, $urandom_range(1), $urandom_range(1));
               end else if ($urandom_range(1) == 1) begin
                  send(KIND_CAND, k, k + 1);
                  k = (k + 1) % (cur_n - 1);
               end else begin
                  send(KIND_CAND, any_vertex(), any_vertex());
               end
            end
         end else begin
            repeat ($urandom_range(4, 1)) send_noise();
         end
      end
   endtask

   initial begin
      int settings[15];
      settings = '{64, 2, 3, 127, 4, 0, 5, 1, 8, 65, 16, 33, 7, 0, 0};
      settings[13] = $urandom_range(127);
      settings[14] = $urandom_range(127);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_vertices(64);
      send(KIND_CLEAR, 63, 63);
      send(KIND_UNUSED, 63, 63);
      send(KIND_FORCED, 0, 63);
      send(KIND_FORCED, 63, 0);
      send(KIND_CAND, 0, 63);
      send(KIND_CAND, 1, 2);
      send(KIND_CAND, 42, 21);
      send(KIND_UNUSED, 0, 0);

      set_vertices(3);
      send(KIND_CLEAR, 0, 0);
      send(KIND_CAND, 0, 5);
      send(KIND_CAND, 0, 1);
      send(KIND_FORCED, 3, 1);
      send(KIND_FORCED, 1, 2);
      send(KIND_FORCED, 0, 2);
      send(KIND_CAND, 0, 2);

      set_vertices(2);
      send(KIND_CLEAR, 0, 0);
      send(KIND_CAND, 0, 0);
      send(KIND_CAND, 0, 1);
      send(KIND_FORCED, 0, 1);
      send(KIND_CLEAR, 0, 0);
      send(KIND_CAND, 1, 0);

      foreach (settings[i]) begin
         set_vertices(settings[i]);
         no_idle = ($urandom_range(3) == 0);
         run_phase(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[kruskal_tree_completion_core] OK");
      end else begin
         $display("[kruskal_tree_completion_core] ERROR");
      end
      $finish;
   end

endmodule
